@@ src/smi_pkg.sv @@
// Shared types, codes and constants of the stack machine interpreter.
package smi_pkg;

  localparam int SMI_STACK_ENTRIES = 32;

  // Command queue between the front and the back; a power of two so the pointers wrap.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_PUSH  = 2'd1;
  localparam logic [1:0] FUNC_EXEC  = 2'd2;

  localparam logic [7:0] OP_DUP  = 8'h00;
  localparam logic [7:0] OP_SWAP = 8'h01;
  localparam logic [7:0] OP_MUL  = 8'h02;
  localparam logic [7:0] OP_ADD  = 8'h03;
  localparam logic [7:0] OP_OVER = 8'h04;

  // Decoded operation kinds carried through the queue.
  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_PUSH  = 3'd1;
  localparam logic [2:0] KIND_DUP   = 3'd2;
  localparam logic [2:0] KIND_SWAP  = 3'd3;
  localparam logic [2:0] KIND_MUL   = 3'd4;
  localparam logic [2:0] KIND_ADD   = 3'd5;
  localparam logic [2:0] KIND_OVER  = 3'd6;
  localparam logic [2:0] KIND_NOP   = 3'd7;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         opcode;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic               error_code;
    logic [5:0]         depth;
    logic signed [31:0] top_value;
    logic signed [31:0] bottom_value;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
  } op_t;

  typedef struct packed {
    logic err;      // sticky stack violation flag
    logic commit;   // an operation retires this cycle
    logic restart;  // the retiring operation is a start
  } stat_t;

endpackage

@@ src/smi_front.sv @@
// Front end: accepts command words, decodes them and queues the decoded operations.
module smi_front
  import smi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic op_valid,
  input  logic op_take,
  output op_t  op
);

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  op_t             dec;
  op_t             slots [QUEUE_DEPTH];
  logic [QPW-1:0]  wr_ptr;
  logic [QPW-1:0]  rd_ptr;
  logic [QCW-1:0]  level;
  logic            push;
  logic            pop;

  always_comb begin
    dec.value = cmd.value;
    unique case (cmd.func)
      FUNC_START: dec.kind = KIND_START;
      FUNC_PUSH:  dec.kind = KIND_PUSH;
      FUNC_EXEC: begin
        unique case (cmd.opcode)
          OP_DUP:  dec.kind = KIND_DUP;
          OP_SWAP: dec.kind = KIND_SWAP;
          OP_MUL:  dec.kind = KIND_MUL;
          OP_ADD:  dec.kind = KIND_ADD;
          OP_OVER: dec.kind = KIND_OVER;
          default: dec.kind = KIND_NOP;
        endcase
      end
      default:    dec.kind = KIND_NOP;
    endcase
  end

  assign cmd_stall = (level == QCW'(QUEUE_DEPTH));
  assign op_valid  = (level != '0);
  assign op        = slots[rd_ptr];
  assign push      = cmd_valid && !cmd_stall;
  assign pop       = op_valid && op_take;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPW'(1);
      end
      if (push && !pop) begin
        level <= level + QCW'(1);
      end else if (pop && !push) begin
        level <= level - QCW'(1);
      end
    end
  end

endmodule

@@ src/smi_back.sv @@
// Back end: executes queued operations on the stack and registers one result per operation.
module smi_back
  import smi_pkg::*;
#(
  parameter int STACK_ENTRIES = SMI_STACK_ENTRIES,
  localparam int AW = $clog2(STACK_ENTRIES),
  localparam int CW = $clog2(STACK_ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_take,
  input  op_t           op,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rsp_t          rsp,
  output logic [CW-1:0] stat_cnt,
  output stat_t         stat
);

  // Top two elements and the bottom one live in registers; deeper ones in memory.
  logic [31:0]   mem [STACK_ENTRIES];
  logic [31:0]   rd_data;
  logic [31:0]   alu_res;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          err;
  logic          err_next;
  logic [31:0]   tos;
  logic [31:0]   tos_next;
  logic [31:0]   nos;
  logic [31:0]   nos_next;
  logic [31:0]   bot;
  logic [31:0]   bot_next;
  logic [31:0]   push_val;
  logic          spill;
  logic [AW-1:0] spill_addr;
  logic [AW-1:0] rd_addr;
  logic          phase;
  logic          out_free;
  logic          two_step;
  logic          fire;
  logic          issue;
  logic          full;
  logic          lt2;
  logic [CW+5:0] depth_ext;

  assign full       = (cnt == CW'(STACK_ENTRIES));
  assign lt2        = (cnt < CW'(2));
  assign spill_addr = AW'(cnt - CW'(2));
  assign rd_addr    = AW'(cnt - CW'(3));
  assign out_free   = !rsp_valid || !rsp_stall;

  // ADD and MUL must fetch the new second element from memory first.
  assign two_step = !err && !lt2 && (op.kind == KIND_ADD || op.kind == KIND_MUL);
  assign issue    = op_valid && two_step && !phase;
  assign fire     = op_valid && out_free && (!two_step || phase);
  assign op_take  = fire;

  always_comb begin
    unique case (op.kind)
      KIND_PUSH: push_val = op.value;
      KIND_DUP:  push_val = tos;
      default:   push_val = nos;
    endcase
  end

  always_comb begin
    cnt_next = cnt;
    err_next = err;
    tos_next = tos;
    nos_next = nos;
    bot_next = bot;
    spill    = 1'b0;
    if (op.kind == KIND_START) begin
      cnt_next = '0;
      err_next = 1'b0;
    end else if (!err) begin
      unique case (op.kind) inside
        KIND_PUSH, KIND_DUP, KIND_OVER: begin
          if (full || (op.kind == KIND_DUP && cnt == '0) || (op.kind == KIND_OVER && lt2)) begin
            err_next = 1'b1;
          end else begin
            spill    = !lt2;
            nos_next = tos;
            tos_next = push_val;
            cnt_next = cnt + CW'(1);
            if (cnt == '0) begin
              bot_next = push_val;
            end
          end
        end
        KIND_SWAP: begin
          if (lt2) begin
            err_next = 1'b1;
          end else begin
            tos_next = nos;
            nos_next = tos;
            if (cnt == CW'(2)) begin
              bot_next = tos;
            end
          end
        end
        KIND_MUL, KIND_ADD: begin
          if (lt2) begin
            err_next = 1'b1;
          end else begin
            tos_next = alu_res;
            nos_next = rd_data;
            cnt_next = cnt - CW'(1);
            if (cnt == CW'(2)) begin
              bot_next = alu_res;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign depth_ext = {6'd0, cnt_next};

  always_ff @(posedge clk) begin
    if (fire && spill) begin
      mem[spill_addr] <= nos;
    end
    if (issue) begin
      rd_data <= mem[rd_addr];
      alu_res <= (op.kind == KIND_MUL) ? 32'(tos * nos) : tos + nos;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tos              <= tos_next;
      nos              <= nos_next;
      bot              <= bot_next;
      rsp.error_code   <= err_next;
      rsp.depth        <= depth_ext[5:0];
      rsp.top_value    <= (cnt_next != '0) ? tos_next : 32'd0;
      rsp.bottom_value <= (cnt_next != '0) ? bot_next : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      err       <= 1'b0;
      phase     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (fire) begin
        cnt   <= cnt_next;
        err   <= err_next;
        phase <= 1'b0;
      end else if (issue) begin
        phase <= 1'b1;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign stat_cnt     = cnt;
  assign stat.err     = err;
  assign stat.commit  = fire;
  assign stat.restart = (op.kind == KIND_START);

endmodule

@@ src/stack_machine_interpreter.sv @@
// Top level of the stack machine interpreter: front decoder and queue, back executor.

// A 32-bit stack machine driven by one command word per item: start empties the stack and
// clears the sticky error, push loads the word's value, and execute runs DUP, SWAP, MUL, ADD
// or OVER (any other opcode does nothing). Every command word returns exactly one result word
// with the error flag, the depth and the top and bottom elements, in command order. Push, DUP,
// SWAP, OVER, start and no-op commands retire at one per cycle unless the result stalls;
// ADD and MUL with two or more operands and no error first read memory, then retire, because
// after the pop the new second element has to come back through the registered read port of
// the stack memory. A two-entry queue between the decoder and the executor, and a result
// register, let each side stall without blocking the other.
module stack_machine_interpreter
  import smi_pkg::*;
#(
  parameter int STACK_ENTRIES = SMI_STACK_ENTRIES
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int CW = $clog2(STACK_ENTRIES + 1);

  logic          op_valid;
  logic          op_take;
  op_t           op;
  logic [CW-1:0] stat_cnt;
  stat_t         stat;

  // The front decodes the command word into an operation kind and queues it.
  smi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .op_valid  (op_valid),
    .op_take   (op_take),
    .op        (op)
  );

  // The back holds the stack and produces one result word per operation.
  smi_back #(
    .STACK_ENTRIES (STACK_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_take   (op_take),
    .op        (op),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .stat_cnt  (stat_cnt),
    .stat      (stat)
  );

`ifndef SYNTHESIS
  // The stack never holds more than its capacity.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    stat_cnt <= CW'(STACK_ENTRIES))
    else $error("stack depth above capacity");

  // Once set, the error stays and the stack is frozen until a start retires.
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    stat.err && !(stat.commit && stat.restart) |=> stat.err && $stable(stat_cnt))
    else $error("sticky error lost or stack changed under error");

  // A retiring start empties the stack and clears the error.
  a_start: assert property (@(posedge clk) disable iff (rst)
    stat.commit && stat.restart |=> stat_cnt == '0 && !stat.err)
    else $error("start did not clear the machine");

  // No result word is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");
`endif

endmodule

@@ bench/stack_machine_interpreter_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the stack machine interpreter, with its own stack predictor.
module stack_machine_interpreter_tb;
  import smi_pkg::*;

  localparam int DEPTH_LIMIT  = SMI_STACK_ENTRIES;
  localparam int RANDOM_WORDS = 1850;
  localparam int DRAIN_EVERY  = 400;
  localparam int MAX_REPORTS  = 10;

  // The func field has one code the block does not use; it must leave the status alone.
  localparam logic [1:0] FUNC_UNUSED      = 2'd3;
  localparam logic [7:0] OP_FIRST_UNKNOWN = 8'h05;
  localparam logic [7:0] OP_LAST_UNKNOWN  = 8'hFF;

  localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_t;

  // One row of the directed table. Where typed is set, want is the result read straight
  // off the behavior; otherwise the predictor supplies the expected word.
  typedef struct packed {
    cmd_t word;
    logic typed;
    rsp_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // Predictor state: a copy of the stack, its fill count and the sticky error.
  logic [31:0] stack_image [DEPTH_LIMIT];
  int unsigned stack_fill;
  logic        sticky_err;

  rsp_t      pending_rsp [$];
  stim_row_t directed_rows [$];

  int fail_count;
  int words_sent;
  int burst_left;

  stall_mode_t stall_mode;
  int          stall_phase_left;
  int          stall_tick;
  int          hold_left;
  logic        hold_state;

  stack_machine_interpreter #(
    .STACK_ENTRIES(DEPTH_LIMIT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // Pushes one entry; a full stack refuses it and stays as it is.
  function automatic logic stack_push(logic [31:0] entry);
    if (stack_fill >= DEPTH_LIMIT) return 1'b0;
    stack_image[stack_fill] = entry;
    stack_fill++;
    return 1'b1;
  endfunction

  // Runs one opcode against the stack copy. A zero return is a stack violation, and in that
  // case nothing has been changed.
  function automatic logic run_opcode(logic [7:0] op);
    logic [31:0] upper;
    logic [31:0] lower;
    case (op)
      OP_DUP: begin
        if (stack_fill < 1) return 1'b0;
        return stack_push(stack_image[stack_fill - 1]);
      end
      OP_SWAP: begin
        if (stack_fill < 2) return 1'b0;
        upper = stack_image[stack_fill - 1];
        stack_image[stack_fill - 1] = stack_image[stack_fill - 2];
        stack_image[stack_fill - 2] = upper;
        return 1'b1;
      end
      OP_MUL, OP_ADD: begin
        if (stack_fill < 2) return 1'b0;
        upper = stack_image[stack_fill - 1];
        lower = stack_image[stack_fill - 2];
        // Both operations keep only the low 32 bits of the unsigned result.
        stack_image[stack_fill - 2] = (op == OP_MUL) ? upper * lower : upper + lower;
        stack_fill--;
        return 1'b1;
      end
      OP_OVER: begin
        if (stack_fill < 2) return 1'b0;
        return stack_push(stack_image[stack_fill - 2]);
      end
      default: return 1'b1;
    endcase
  endfunction

  // Applies one accepted command word and returns the status word the block owes for it.
  function automatic rsp_t advance_machine(cmd_t word);
    rsp_t status;
    if (word.func == FUNC_START) begin
      stack_fill = 0;
      sticky_err = 1'b0;
    end else if (!sticky_err) begin
      if (word.func == FUNC_PUSH) begin
        if (!stack_push(word.value)) sticky_err = 1'b1;
      end else if (word.func == FUNC_EXEC) begin
        if (!run_opcode(word.opcode)) sticky_err = 1'b1;
      end
    end
    status.error_code = sticky_err;
    status.depth      = stack_fill[5:0];
    if (stack_fill > 0) begin
      status.top_value    = stack_image[stack_fill - 1];
      status.bottom_value = stack_image[0];
    end else begin
      status.top_value    = '0;
      status.bottom_value = '0;
    end
    return status;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  function automatic logic [7:0] known_op(int unsigned idx);
    case (idx)
      0:       return OP_DUP;
      1:       return OP_SWAP;
      2:       return OP_MUL;
      3:       return OP_ADD;
      default: return OP_OVER;
    endcase
  endfunction

  // Mostly uniform words, with the corners mixed in so that products and sums wrap often.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return WORD_ONES;
      4:       return 32'h1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_unknown_op();
    return 8'($urandom_range(OP_FIRST_UNKNOWN, OP_LAST_UNKNOWN));
  endfunction

  task automatic add_row(input logic [1:0] func, input logic [7:0] opcode,
                         input logic [31:0] value, input logic typed, input logic err,
                         input logic [5:0] depth, input logic [31:0] top,
                         input logic [31:0] bottom);
    stim_row_t row;
    row.word.func         = func;
    row.word.opcode       = opcode;
    row.word.value        = value;
    row.typed             = typed;
    row.want.error_code   = err;
    row.want.depth        = depth;
    row.want.top_value    = top;
    row.want.bottom_value = bottom;
    directed_rows.push_back(row);
  endtask

  // Drives one command word, starting at a falling edge, and holds it until it is taken.
  // The sender runs in bursts; a gap with valid low opens when a burst is used up.
  // The expectation is queued at the very edge of acceptance, so the stack copy is always
  // up to date when the sequence generators look at it for the next word.
  task automatic send_word(input cmd_t word, input logic typed, input rsp_t want);
    rsp_t predicted;
    if (burst_left == 0) begin
      cmd_valid = 1'b0;
      cmd.value = $urandom;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 24);
    end
    cmd_valid = 1'b1;
    cmd       = word;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predicted = advance_machine(word);
    pending_rsp.push_back(typed ? want : predicted);
    burst_left--;
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_plain(input logic [1:0] func, input logic [7:0] opcode,
                            input logic [31:0] value);
    cmd_t word;
    word.func   = func;
    word.opcode = opcode;
    word.value  = value;
    send_word(word, 1'b0, '0);
  endtask

  // Holds the sender back until every result owed so far has come out.
  task automatic drain_results();
    cmd_valid = 1'b0;
    do @(negedge clk); while (pending_rsp.size() != 0);
  endtask

  // A well-formed program: start, then a random walk of pushes and opcodes that mostly
  // keeps enough operands on the stack and never overfills it.
  task automatic run_program();
    int steps;
    int k;
    int roll;
    steps = $urandom_range(4, 48);
    send_plain(FUNC_START, 8'($urandom_range(0, 255)), pick_value());
    for (k = 0; k < steps && !sticky_err; k++) begin
      roll = $urandom_range(0, 99);
      if (stack_fill == 0 || (stack_fill < DEPTH_LIMIT && roll < 35)) begin
        send_plain(FUNC_PUSH, 8'($urandom_range(0, 255)), pick_value());
      end else if (stack_fill == 1) begin
        send_plain(FUNC_EXEC, (roll < 85) ? OP_DUP : pick_unknown_op(), pick_value());
      end else if (stack_fill >= DEPTH_LIMIT) begin
        send_plain(FUNC_EXEC, known_op($urandom_range(1, 3)), pick_value());
      end else begin
        send_plain(FUNC_EXEC, (roll < 92) ? known_op($urandom_range(0, 4)) : pick_unknown_op(),
                   pick_value());
      end
    end
  endtask

  // Fills the stack to the top, then overflows it with a push, a DUP or an OVER, and sends
  // a few words that the sticky error must swallow.
  task automatic run_fill();
    int roll;
    send_plain(FUNC_START, 8'($urandom_range(0, 255)), pick_value());
    while (stack_fill < DEPTH_LIMIT) begin
      roll = $urandom_range(0, 99);
      if (stack_fill >= 2 && roll < 15) send_plain(FUNC_EXEC, OP_OVER, pick_value());
      else if (stack_fill >= 1 && roll < 30) send_plain(FUNC_EXEC, OP_DUP, pick_value());
      else send_plain(FUNC_PUSH, 8'($urandom_range(0, 255)), pick_value());
    end
    if ($urandom_range(0, 1) == 1) begin
      // Legal work on a full stack, then back to full.
      send_plain(FUNC_EXEC, OP_SWAP, pick_value());
      send_plain(FUNC_EXEC, ($urandom_range(0, 1) == 1) ? OP_MUL : OP_ADD, pick_value());
      send_plain(FUNC_PUSH, 8'($urandom_range(0, 255)), pick_value());
    end
    case ($urandom_range(0, 2))
      0:       send_plain(FUNC_PUSH, 8'($urandom_range(0, 255)), pick_value());
      1:       send_plain(FUNC_EXEC, OP_DUP, pick_value());
      default: send_plain(FUNC_EXEC, OP_OVER, pick_value());
    endcase
    repeat ($urandom_range(1, 3))
      send_plain(2'($urandom_range(FUNC_PUSH, FUNC_EXEC)), 8'($urandom_range(0, 255)),
                 pick_value());
  endtask

  // Starts, leaves zero or one operand, and runs an opcode that needs more.
  task automatic run_underflow();
    int kept;
    send_plain(FUNC_START, 8'($urandom_range(0, 255)), pick_value());
    kept = $urandom_range(0, 1);
    repeat (kept) send_plain(FUNC_PUSH, 8'($urandom_range(0, 255)), pick_value());
    send_plain(FUNC_EXEC, known_op($urandom_range(kept, 4)), pick_value());
    repeat ($urandom_range(1, 3))
      send_plain(2'($urandom_range(FUNC_PUSH, FUNC_EXEC)), 8'($urandom_range(0, 255)),
                 pick_value());
  endtask

  // Fully random words, the unused func code included.
  task automatic run_noise();
    repeat ($urandom_range(1, 8))
      send_plain(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom);
  endtask

  // ---------------------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------------------

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_rsp(input rsp_t got);
    rsp_t  want;
    string fields;
    if (pending_rsp.size() == 0) begin
      log_failure($sformatf("result word with nothing owed: err=%0d depth=%0d top=%h bottom=%h",
                            got.error_code, got.depth, got.top_value, got.bottom_value));
      return;
    end
    want   = pending_rsp.pop_front();
    fields = "";
    if (got.error_code !== want.error_code)     fields = {fields, " error_code"};
    if (got.depth !== want.depth)               fields = {fields, " depth"};
    if (got.top_value !== want.top_value)       fields = {fields, " top_value"};
    if (got.bottom_value !== want.bottom_value) fields = {fields, " bottom_value"};
    if (fields != "")
      log_failure($sformatf({"mismatch in%s: expected err=%0d depth=%0d top=%h bottom=%h,",
                             " got err=%0d depth=%0d top=%h bottom=%h"}, fields,
                            want.error_code, want.depth, want.top_value, want.bottom_value,
                            got.error_code, got.depth, got.top_value, got.bottom_value));
  endtask

  // A result word moves at a rising edge where valid is high and our stall is low.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) check_rsp(rsp);
  end

  // ---------------------------------------------------------------------------------------
  // Receiver: stalls on its own pattern, switching between no stalls, random stalls, a
  // fixed rhythm and long holds, so that stalls meet the block in every phase of its work.
  // ---------------------------------------------------------------------------------------
  initial begin
    rsp_stall        = 1'b0;
    stall_mode       = STALL_NONE;
    stall_phase_left = 200;
    stall_tick       = 0;
    hold_left        = 0;
    hold_state       = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_phase_left == 0) begin
        stall_mode       = stall_mode_t'($urandom_range(0, 3));
        stall_phase_left = $urandom_range(50, 300);
      end
      stall_phase_left--;
      stall_tick++;
      case (stall_mode)
        STALL_NONE:     rsp_stall = 1'b0;
        STALL_RANDOM:   rsp_stall = ($urandom_range(0, 99) < 35);
        STALL_PERIODIC: rsp_stall = ((stall_tick % 5) >= 3);
        default: begin
          if (hold_left == 0) begin
            hold_state = ~hold_state;
            hold_left  = hold_state ? $urandom_range(1, 16) : $urandom_range(1, 10);
          end
          hold_left--;
          rsp_stall = hold_state;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Main sequence: reset, the directed table, then random sequences, then the tail wait.
  // ---------------------------------------------------------------------------------------
  initial begin
    int i;
    int roll;
    int random_start;
    int next_drain;
    int tail_wait;

    rst        = 1'b1;
    cmd_valid  = 1'b0;
    cmd        = '0;
    burst_left = 0;
    fail_count = 0;
    words_sent = 0;
    stack_fill = 0;
    sticky_err = 1'b0;
    for (i = 0; i < DEPTH_LIMIT; i++) stack_image[i] = '0;

    // Directed table. Typed rows carry their result by hand; the rest use the predictor.
    add_row(FUNC_START, OP_DUP, '0, 1'b1, 1'b0, 6'd0, '0, '0);
    add_row(FUNC_PUSH, OP_DUP, WORD_MAX, 1'b1, 1'b0, 6'd1, WORD_MAX, WORD_MAX);
    add_row(FUNC_PUSH, 8'hFF, WORD_MIN, 1'b1, 1'b0, 6'd2, WORD_MIN, WORD_MAX);
    // The largest and smallest words add up to all ones.
    add_row(FUNC_EXEC, OP_ADD, '0, 1'b1, 1'b0, 6'd1, WORD_ONES, WORD_ONES);
    add_row(FUNC_PUSH, OP_MUL, WORD_ONES, 1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_EXEC, OP_MUL, WORD_ONES, 1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_EXEC, OP_DUP, WORD_MIN, 1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_PUSH, OP_OVER, 32'h1234_5678, 1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_EXEC, OP_SWAP, '0, 1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_EXEC, OP_OVER, '0, 1'b0, 1'b0, '0, '0, '0);
    // Unknown opcodes at both ends of their range, then the unused func code.
    add_row(FUNC_EXEC, OP_FIRST_UNKNOWN, WORD_ONES, 1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_EXEC, OP_LAST_UNKNOWN, WORD_MAX, 1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_UNUSED, 8'hAA, 32'hDEAD_BEEF, 1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_PUSH, OP_SWAP, '0, 1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_EXEC, OP_ADD, '0, 1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_EXEC, OP_MUL, '0, 1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_EXEC, OP_MUL, '0, 1'b0, 1'b0, '0, '0, '0);
    add_row(FUNC_START, OP_LAST_UNKNOWN, WORD_ONES, 1'b1, 1'b0, 6'd0, '0, '0);
    // Underflow on an empty stack sets the error; the error then holds against a push and a
    // DUP, and only a start clears it.
    add_row(FUNC_EXEC, OP_SWAP, '0, 1'b1, 1'b1, 6'd0, '0, '0);
    add_row(FUNC_PUSH, OP_DUP, 32'h5, 1'b1, 1'b1, 6'd0, '0, '0);
    add_row(FUNC_EXEC, OP_DUP, '0, 1'b1, 1'b1, 6'd0, '0, '0);
    add_row(FUNC_START, OP_DUP, '0, 1'b1, 1'b0, 6'd0, '0, '0);
    add_row(FUNC_PUSH, OP_DUP, 32'h1, 1'b1, 1'b0, 6'd1, 32'h1, 32'h1);
    // An ADD with a single operand underflows and leaves that operand in place.
    add_row(FUNC_EXEC, OP_ADD, '0, 1'b1, 1'b1, 6'd1, 32'h1, 32'h1);
    add_row(FUNC_START, OP_DUP, '0, 1'b1, 1'b0, 6'd0, '0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < directed_rows.size(); i++)
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

    // Let the pipeline run empty once before the random part.
    drain_results();
    burst_left = 0;

    random_start = words_sent;
    next_drain   = words_sent + DRAIN_EVERY;
    while (words_sent - random_start < RANDOM_WORDS) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) run_program();
      else if (roll < 67) run_fill();
      else if (roll < 82) run_underflow();
      else run_noise();
      if (words_sent >= next_drain) begin
        drain_results();
        next_drain += DRAIN_EVERY;
      end
    end

    // Wait for the last results, with a bound, then keep watching the output so that a stray
    // extra word would still be caught.
    cmd_valid = 1'b0;
    tail_wait = 0;
    while (pending_rsp.size() != 0 && tail_wait < 5000) begin
      @(negedge clk);
      tail_wait++;
    end
    repeat (20) @(negedge clk);
    if (pending_rsp.size() != 0)
      log_failure($sformatf("%0d expected result words never arrived", pending_rsp.size()));

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
src/smi_pkg.sv
src/smi_front.sv
src/smi_back.sv
src/stack_machine_interpreter.sv
bench/stack_machine_interpreter_tb.sv
